[hw/rtl/pqb_pkg.sv]
// ----------------------------------------------------------------------------
// pqb_pkg
// Shared codes and the command and status structures that join the queue
// bank controller to its datapath.
// ----------------------------------------------------------------------------
package pqb_pkg;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_COPY = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic clear_step;
		logic capture;
		logic queue_decide;
		logic push_step;
		logic pop_step;
		logic pop_resolve;
		logic pop_finish;
		logic load_out;
	} pqb_cmd_t;

	typedef struct packed {
		logic       clear_last;
		logic [1:0] op;
		logic       pool_full;
		logic       queue_empty;
		logic       push_last;
		logic       pop_last;
		logic       out_free;
	} pqb_stat_t;

endpackage

[hw/rtl/pqb_ctrl.sv]
// ----------------------------------------------------------------------------
// pqb_ctrl
// Sequencer of the queue bank: clearing pass, request capture, queue table
// decision, link walks for push and pop, and the result hand-off.
// ----------------------------------------------------------------------------
module pqb_ctrl
	import pqb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output pqb_cmd_t  cmd,
	input  pqb_stat_t stat
);

	localparam logic [2:0] S_CLEAR   = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_QREAD   = 3'd2;
	localparam logic [2:0] S_PUSH    = 3'd3;
	localparam logic [2:0] S_POP     = 3'd4;
	localparam logic [2:0] S_RESOLVE = 3'd5;
	localparam logic [2:0] S_FETCH   = 3'd6;
	localparam logic [2:0] S_DONE    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_QREAD;
				end
			end
			S_QREAD: begin
				cmd.queue_decide = 1'b1;
				if (stat.op == OP_PUSH && !stat.pool_full) begin
					state_d = S_PUSH;
				end else if (stat.op == OP_POP && !stat.queue_empty) begin
					state_d = S_POP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_PUSH: begin
				cmd.push_step = 1'b1;
				if (stat.push_last) begin
					state_d = S_DONE;
				end
			end
			S_POP: begin
				cmd.pop_step = 1'b1;
				if (stat.pop_last) begin
					state_d = S_RESOLVE;
				end
			end
			S_RESOLVE: begin
				cmd.pop_resolve = 1'b1;
				state_d         = S_FETCH;
			end
			S_FETCH: begin
				cmd.pop_finish = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/pqb_dpath.sv]
// ----------------------------------------------------------------------------
// pqb_dpath
// Storage and arithmetic of the queue bank: queue table, node values, jump
// links, the link walker and the output register.
// ----------------------------------------------------------------------------
module pqb_dpath
	import pqb_pkg::*;
#(
	parameter int NODES       = 65536,
	parameter int JUMP_LEVELS = 16,
	parameter int QUEUES      = 256,
	parameter int VALUE_BITS  = 32
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  pqb_cmd_t    cmd,
	output pqb_stat_t   stat,
	input  logic [1:0]  op,
	input  logic [31:0] data_value,
	input  logic [7:0]  target_queue,
	input  logic [7:0]  source_queue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] popped_value,
	output logic [1:0]  status
);

	localparam int NB         = $clog2(NODES);
	localparam int LB         = $clog2(JUMP_LEVELS);
	localparam int QB         = $clog2(QUEUES);
	localparam int LA         = NB + LB;
	localparam int LINK_DEPTH = NODES << LB;
	localparam int VW         = (VALUE_BITS > 32) ? VALUE_BITS : 32;
	localparam int RW         = (NB > JUMP_LEVELS) ? NB : JUMP_LEVELS;

	// Queue index reduction table, one entry per possible 8-bit index.
	logic [QB-1:0] qidx_tbl [0:255];
	for (genvar g = 0; g < 256; g++) begin : g_qidx
		assign qidx_tbl[g] = QB'(g % QUEUES);
	end

	logic [2*NB-1:0]       qmem [0:QUEUES-1];
	logic [NB-1:0]         lmem [0:LINK_DEPTH-1];
	logic [VALUE_BITS-1:0] nmem [0:NODES-1];

	logic [2*NB-1:0]       q_rdata_q;
	logic [NB-1:0]         link_rdata_q;
	logic [VALUE_BITS-1:0] node_rdata_q;

	logic [1:0]            op_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [QB-1:0]         tq_q;
	logic [NB-1:0]         nfn_q;
	logic [LB-1:0]         level_q;
	logic [NB-1:0]         node_q;
	logic                  pend_q;
	logic                  zero_q;
	logic [JUMP_LEVELS-1:0] remain_q;
	logic [QB-1:0]         clr_idx_q;
	logic [31:0]           res_value_q;
	logic [1:0]            res_status_q;
	logic [31:0]           popped_value_q;
	logic [1:0]            status_q;
	logic                  out_valid_q;

	logic [NB-1:0]         q_tail;
	logic [NB-1:0]         q_size;
	logic [NB-1:0]         new_node;
	logic [NB-1:0]         rd_eff;
	logic [NB-1:0]         cur;
	logic                  pool_full;
	logic                  queue_empty;
	logic [RW-1:0]         remain_ext;
	logic [VW-1:0]         value_ext;
	logic [VW-1:0]         node_ext;

	logic                  qm_we;
	logic [QB-1:0]         qm_waddr;
	logic [2*NB-1:0]       qm_wdata;
	logic                  lm_we;
	logic [LA-1:0]         lm_waddr;
	logic [NB-1:0]         lm_wdata;
	logic                  lm_re;
	logic [LA-1:0]         lm_raddr;

	always_comb begin
		q_tail      = q_rdata_q[2*NB-1:NB];
		q_size      = q_rdata_q[NB-1:0];
		new_node    = nfn_q + NB'(1);
		pool_full   = (nfn_q == NB'(NODES - 1));
		queue_empty = (q_size == '0);
		rd_eff      = zero_q ? '0 : link_rdata_q;
		cur         = pend_q ? rd_eff : node_q;
		remain_ext  = RW'(q_size - NB'(1));
		value_ext   = VW'(data_value);
		node_ext    = VW'(node_rdata_q);

		qm_we    = 1'b0;
		qm_waddr = tq_q;
		qm_wdata = q_rdata_q;
		if (cmd.clear_step) begin
			qm_we    = 1'b1;
			qm_waddr = clr_idx_q;
			qm_wdata = '0;
		end else if (cmd.queue_decide) begin
			case (op_q)
				OP_PUSH: begin
					qm_we    = !pool_full;
					qm_wdata = {new_node, q_size + NB'(1)};
				end
				OP_POP: begin
					qm_we    = !queue_empty;
					qm_wdata = {q_tail, q_size - NB'(1)};
				end
				OP_COPY: begin
					qm_we = 1'b1;
				end
				default: begin
					qm_we = 1'b0;
				end
			endcase
		end

		// The first link of a new node is the old tail; each further link is
		// the previous level's link followed once more.
		lm_we    = 1'b0;
		lm_waddr = {new_node, LB'(0)};
		lm_wdata = q_tail;
		lm_re    = 1'b0;
		lm_raddr = {q_tail, LB'(0)};
		if (cmd.queue_decide && op_q == OP_PUSH && !pool_full) begin
			lm_we = 1'b1;
			lm_re = 1'b1;
		end else if (cmd.push_step) begin
			lm_we    = 1'b1;
			lm_waddr = {nfn_q, level_q};
			lm_wdata = cur;
			lm_re    = 1'b1;
			lm_raddr = {cur, level_q};
		end else if (cmd.pop_step) begin
			lm_re    = remain_q[level_q];
			lm_raddr = {cur, level_q};
		end

		stat.clear_last  = (clr_idx_q == QB'(QUEUES - 1));
		stat.op          = op_q;
		stat.pool_full   = pool_full;
		stat.queue_empty = queue_empty;
		stat.push_last   = (level_q == LB'(JUMP_LEVELS - 1));
		stat.pop_last    = (level_q == '0);
		stat.out_free    = !out_valid_q || !out_stall;
	end

	// Memories.
	always_ff @(posedge clk) begin
		if (qm_we) begin
			qmem[qm_waddr] <= qm_wdata;
		end
		if (cmd.capture) begin
			q_rdata_q <= qmem[(op == OP_COPY) ? qidx_tbl[source_queue]
			                                  : qidx_tbl[target_queue]];
		end
	end

	always_ff @(posedge clk) begin
		if (lm_we) begin
			lmem[lm_waddr] <= lm_wdata;
		end
		if (lm_re) begin
			link_rdata_q <= lmem[lm_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.queue_decide && op_q == OP_PUSH && !pool_full) begin
			nmem[new_node] <= value_q;
		end
		if (cmd.pop_resolve) begin
			node_rdata_q <= nmem[cur];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			value_q <= value_ext[VALUE_BITS-1:0];
			tq_q    <= qidx_tbl[target_queue];
		end
		if (cmd.queue_decide) begin
			node_q   <= q_tail;
			remain_q <= remain_ext[JUMP_LEVELS-1:0];
			zero_q   <= (q_tail == '0);
			res_value_q <= '0;
			case (op_q)
				OP_PUSH: res_status_q <= pool_full ? ST_FULL : ST_OK;
				OP_POP:  res_status_q <= queue_empty ? ST_EMPTY : ST_OK;
				default: res_status_q <= ST_OK;
			endcase
		end
		if (cmd.push_step || cmd.pop_step) begin
			node_q <= cur;
			zero_q <= (cur == '0);
		end
		if (cmd.pop_finish) begin
			res_value_q <= node_ext[31:0];
		end
		if (cmd.load_out) begin
			popped_value_q <= res_value_q;
			status_q       <= res_status_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nfn_q       <= '0;
			level_q     <= '0;
			pend_q      <= 1'b0;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_idx_q <= clr_idx_q + QB'(1);
			end
			if (cmd.queue_decide) begin
				if (op_q == OP_PUSH) begin
					if (!pool_full) begin
						nfn_q <= new_node;
					end
					level_q <= LB'(1);
					pend_q  <= 1'b1;
				end else begin
					level_q <= LB'(JUMP_LEVELS - 1);
					pend_q  <= 1'b0;
				end
			end
			if (cmd.push_step) begin
				level_q <= level_q + LB'(1);
			end
			if (cmd.pop_step) begin
				level_q <= level_q - LB'(1);
				pend_q  <= remain_q[level_q];
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = popped_value_q;
	assign status       = status_q;

endmodule

[hw/rtl/persistent_queue_bank.sv]
// A push or a pop walks the jump links through the single jump link memory port, read at most
// once per link level; a copy or an empty or refused request takes no walk. A new request is
// accepted only after the previous result has been loaded into the output register.
// After reset the queue table is cleared one entry per cycle while input requests are
// stalled; node values and links need no clearing.
// ----------------------------------------------------------------------------
// persistent_queue_bank
// A bank of first-in-first-out queues that share one append-only node pool.
// ----------------------------------------------------------------------------
//
// Each queue is held as a tail node and a size in the queue table. A push
// takes the next free node, stores the value and writes its jump links: link
// level i points 2^i nodes back along the chain, built by following link i-1
// of the node that link i-1 points at. A pop reaches the front of the queue by
// walking size-1 nodes back from the tail, one link level per cycle from the
// highest level down, then reads the front node's value. A copy makes the
// target queue share the source queue's tail and size. Node 0 is the null
// node: every link read from it answers zero, so it is never stored.
//
// The controller sequences each request; the datapath holds the memories, the
// link walker and the output register, so a finished result may wait there
// while the next request is already accepted.
module persistent_queue_bank
	import pqb_pkg::*;
#(
	parameter int NODES       = 65536,
	parameter int JUMP_LEVELS = 16,
	parameter int QUEUES      = 256,
	parameter int VALUE_BITS  = 32
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] data_value,
	input  logic [7:0]  target_queue,
	input  logic [7:0]  source_queue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] popped_value,
	output logic [1:0]  status
);

	pqb_cmd_t  cmd;
	pqb_stat_t stat;

	// The controller decides only on status flags; all indices stay in the
	// datapath.
	pqb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	pqb_dpath #(
		.NODES       (NODES),
		.JUMP_LEVELS (JUMP_LEVELS),
		.QUEUES      (QUEUES),
		.VALUE_BITS  (VALUE_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (op),
		.data_value   (data_value),
		.target_queue (target_queue),
		.source_queue (source_queue),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.popped_value (popped_value),
		.status       (status)
	);

endmodule
